### rtl/core/orthonormal_basis_from_normal_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the orthonormal basis unit
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ORTHONORMAL_BASIS_FROM_NORMAL_UNIT_DEFINES_SVH
`define ORTHONORMAL_BASIS_FROM_NORMAL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define OBFN_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define OBFN_ASSERT_NEVER(lbl, clk, rstn, bad, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(bad)) else $error(msg);
`else
`define OBFN_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define OBFN_ASSERT_NEVER(lbl, clk, rstn, bad, msg)
`endif

`endif

### rtl/core/obfn_pkg.sv
// ----------------------------------------------------------------------------
// obfn_pkg
// Widths, lane indices and lane payload type of the orthonormal basis unit.
// ----------------------------------------------------------------------------
package obfn_pkg;

	localparam int IN_WIDTH      = 32;
	localparam int OUT_FRAC_BITS = 30;

	localparam int OUT_W   = OUT_FRAC_BITS + 2;
	localparam int SQ_W    = 2 * IN_WIDTH;
	localparam int NUM_W   = 4 * IN_WIDTH;
	localparam int NSTEP   = OUT_FRAC_BITS + 2;
	localparam int ROOT_W  = OUT_FRAC_BITS + 2;
	localparam int PROD_W  = NUM_W + ROOT_W;
	localparam int REM_W   = NUM_W + 2 * OUT_FRAC_BITS + 5;
	localparam int NLANE   = 9;

	localparam int FRONT_ST = 5;
	localparam int LANE_ST  = NSTEP + 1;
	localparam int PIPE_ST  = FRONT_ST + LANE_ST;

	localparam int IN_TDATA_W  = ((3 * IN_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((NLANE * OUT_W + 7) / 8) * 8;

	localparam int LANE_XX = 0;
	localparam int LANE_XY = 1;
	localparam int LANE_XZ = 2;
	localparam int LANE_YX = 3;
	localparam int LANE_YY = 4;
	localparam int LANE_YZ = 5;
	localparam int LANE_ZX = 6;
	localparam int LANE_ZY = 7;
	localparam int LANE_ZZ = 8;

	// one output component: result = round(sqrt(num / den) * 2^F), signed
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
		logic             neg;
		logic             kill;
	} lane_in_t;

endpackage

### rtl/core/obfn_front.sv
// ----------------------------------------------------------------------------
// obfn_front
// Magnitudes, products, axis lengths and the wide x-axis terms; builds the
// numerator/denominator pair of each of the nine output lanes.
// ----------------------------------------------------------------------------
module obfn_front (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic signed [obfn_pkg::IN_WIDTH-1:0]       dir_x,
	input  logic signed [obfn_pkg::IN_WIDTH-1:0]       dir_y,
	input  logic signed [obfn_pkg::IN_WIDTH-1:0]       dir_z,
	output obfn_pkg::lane_in_t [obfn_pkg::NLANE-1:0]   lanes
);

	localparam int IW = obfn_pkg::IN_WIDTH;
	localparam int SW = obfn_pkg::SQ_W;
	localparam int NW = obfn_pkg::NUM_W;

	logic [IW-1:0] ux, uy, uz;

	logic [IW-1:0] mag_x_s1, mag_y_s1, mag_z_s1;
	logic          neg_x_s1, neg_y_s1, neg_z_s1, deg_s1;

	logic [SW-1:0] sq_x_s2, sq_y_s2, sq_z_s2, xy_s2, xz_s2, yz_s2;
	logic          neg_x_s2, neg_y_s2, neg_z_s2, deg_s2, sel_s2;

	logic [SW-1:0] lz_s3, ly_s3, m1_s3, m2_s3;
	logic [SW-1:0] yn_s3 [3];
	logic [SW-1:0] zn_s3 [3];
	logic [obfn_pkg::NLANE-1:0] sgn_s3;
	logic          sel_s3, deg_s3;

	logic [SW-1:0] lz_s4, ly_s4;
	logic [SW-1:0] yn_s4 [3];
	logic [SW-1:0] zn_s4 [3];
	logic [SW-1:0] pd_ll_s4, pd_lh_s4, pd_hl_s4, pd_hh_s4;
	logic [SW-1:0] p1_ll_s4, p1_lh_s4, p1_hh_s4;
	logic [SW-1:0] p2_ll_s4, p2_lh_s4, p2_hh_s4;
	logic [obfn_pkg::NLANE-1:0] sgn_s4;
	logic          sel_s4, deg_s4;

	logic [NW-1:0] lylz, m1sq, m2sq;

	obfn_pkg::lane_in_t [obfn_pkg::NLANE-1:0] lanes_s5;

	assign ux = dir_x;
	assign uy = dir_y;
	assign uz = dir_z;

	// magnitudes; the most negative code maps to 2^(IW-1)
	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s1 <= ux[IW-1] ? (~ux + 1'b1) : ux;
			mag_y_s1 <= uy[IW-1] ? (~uy + 1'b1) : uy;
			mag_z_s1 <= uz[IW-1] ? (~uz + 1'b1) : uz;
			neg_x_s1 <= ux[IW-1];
			neg_y_s1 <= uy[IW-1];
			neg_z_s1 <= uz[IW-1];
			deg_s1   <= (ux == '0) && (uy == '0) && (uz == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s2  <= mag_x_s1 * mag_x_s1;
			sq_y_s2  <= mag_y_s1 * mag_y_s1;
			sq_z_s2  <= mag_z_s1 * mag_z_s1;
			xy_s2    <= mag_x_s1 * mag_y_s1;
			xz_s2    <= mag_x_s1 * mag_z_s1;
			yz_s2    <= mag_y_s1 * mag_z_s1;
			sel_s2   <= mag_y_s1 > mag_x_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			neg_z_s2 <= neg_z_s1;
			deg_s2   <= deg_s1;
		end
	end

	// sel: y axis from k x (1,0,0), else from k x (0,1,0)
	always_ff @(posedge clk) begin
		if (en) begin
			lz_s3    <= sq_x_s2 + sq_y_s2 + sq_z_s2;
			ly_s3    <= sel_s2 ? (sq_y_s2 + sq_z_s2) : (sq_x_s2 + sq_z_s2);
			m1_s3    <= xy_s2;
			m2_s3    <= sel_s2 ? xz_s2 : yz_s2;
			yn_s3[0] <= sel_s2 ? '0 : sq_z_s2;
			yn_s3[1] <= sel_s2 ? sq_z_s2 : '0;
			yn_s3[2] <= sel_s2 ? sq_y_s2 : sq_x_s2;
			zn_s3[0] <= sq_x_s2;
			zn_s3[1] <= sq_y_s2;
			zn_s3[2] <= sq_z_s2;
			sgn_s3[obfn_pkg::LANE_XX] <= sel_s2 ? 1'b0 : ~(neg_x_s2 ^ neg_y_s2);
			sgn_s3[obfn_pkg::LANE_XY] <= sel_s2 ? ~(neg_x_s2 ^ neg_y_s2) : 1'b0;
			sgn_s3[obfn_pkg::LANE_XZ] <= sel_s2 ? ~(neg_x_s2 ^ neg_z_s2)
			                                    : ~(neg_y_s2 ^ neg_z_s2);
			sgn_s3[obfn_pkg::LANE_YX] <= sel_s2 ? 1'b0 : ~neg_z_s2;
			sgn_s3[obfn_pkg::LANE_YY] <= sel_s2 ? neg_z_s2 : 1'b0;
			sgn_s3[obfn_pkg::LANE_YZ] <= sel_s2 ? ~neg_y_s2 : neg_x_s2;
			sgn_s3[obfn_pkg::LANE_ZX] <= neg_x_s2;
			sgn_s3[obfn_pkg::LANE_ZY] <= neg_y_s2;
			sgn_s3[obfn_pkg::LANE_ZZ] <= neg_z_s2;
			sel_s3   <= sel_s2;
			deg_s3   <= deg_s2;
		end
	end

	// wide products split into half-word partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pd_ll_s4 <= ly_s3[IW-1:0]  * lz_s3[IW-1:0];
			pd_lh_s4 <= ly_s3[IW-1:0]  * lz_s3[SW-1:IW];
			pd_hl_s4 <= ly_s3[SW-1:IW] * lz_s3[IW-1:0];
			pd_hh_s4 <= ly_s3[SW-1:IW] * lz_s3[SW-1:IW];
			p1_ll_s4 <= m1_s3[IW-1:0]  * m1_s3[IW-1:0];
			p1_lh_s4 <= m1_s3[IW-1:0]  * m1_s3[SW-1:IW];
			p1_hh_s4 <= m1_s3[SW-1:IW] * m1_s3[SW-1:IW];
			p2_ll_s4 <= m2_s3[IW-1:0]  * m2_s3[IW-1:0];
			p2_lh_s4 <= m2_s3[IW-1:0]  * m2_s3[SW-1:IW];
			p2_hh_s4 <= m2_s3[SW-1:IW] * m2_s3[SW-1:IW];
			lz_s4    <= lz_s3;
			ly_s4    <= ly_s3;
			yn_s4    <= yn_s3;
			zn_s4    <= zn_s3;
			sgn_s4   <= sgn_s3;
			sel_s4   <= sel_s3;
			deg_s4   <= deg_s3;
		end
	end

	assign lylz = (NW'(pd_hh_s4) << SW) + ((NW'(pd_lh_s4) + NW'(pd_hl_s4)) << IW)
	            + NW'(pd_ll_s4);
	assign m1sq = (NW'(p1_hh_s4) << SW) + (NW'(p1_lh_s4) << (IW + 1)) + NW'(p1_ll_s4);
	assign m2sq = (NW'(p2_hh_s4) << SW) + (NW'(p2_lh_s4) << (IW + 1)) + NW'(p2_ll_s4);

	// x axis: the length-squared component reduces to ly/lz
	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s5[obfn_pkg::LANE_XX].num <= sel_s4 ? NW'(ly_s4) : m1sq;
			lanes_s5[obfn_pkg::LANE_XX].den <= sel_s4 ? NW'(lz_s4) : lylz;
			lanes_s5[obfn_pkg::LANE_XY].num <= sel_s4 ? m1sq : NW'(ly_s4);
			lanes_s5[obfn_pkg::LANE_XY].den <= sel_s4 ? lylz : NW'(lz_s4);
			lanes_s5[obfn_pkg::LANE_XZ].num <= m2sq;
			lanes_s5[obfn_pkg::LANE_XZ].den <= lylz;
			for (int i = 0; i < 3; i++) begin
				lanes_s5[obfn_pkg::LANE_YX + i].num <= NW'(yn_s4[i]);
				lanes_s5[obfn_pkg::LANE_YX + i].den <= NW'(ly_s4);
				lanes_s5[obfn_pkg::LANE_ZX + i].num <= NW'(zn_s4[i]);
				lanes_s5[obfn_pkg::LANE_ZX + i].den <= NW'(lz_s4);
			end
			for (int i = 0; i < obfn_pkg::NLANE; i++) begin
				lanes_s5[i].neg  <= sgn_s4[i];
				lanes_s5[i].kill <= deg_s4;
			end
		end
	end

	assign lanes = lanes_s5;

endmodule

### rtl/core/obfn_lane.sv
// ----------------------------------------------------------------------------
// obfn_lane
// One output component: restoring square-root-of-quotient recurrence, one
// root bit per stage, then round to nearest (ties away) and apply the sign.
// ----------------------------------------------------------------------------
module obfn_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  obfn_pkg::lane_in_t                   lane_in,
	output logic signed [obfn_pkg::OUT_W-1:0]    q,
	output logic                                 kill
);

	localparam int NS = obfn_pkg::NSTEP;
	localparam int RW = obfn_pkg::REM_W;
	localparam int PW = obfn_pkg::PROD_W;
	localparam int QW = obfn_pkg::ROOT_W;
	localparam int NW = obfn_pkg::NUM_W;
	localparam int OW = obfn_pkg::OUT_W;

	// invariant: rem = num * 2^(2F+2) - root^2 * den, prod = root * den
	logic [RW-1:0] rem_c  [NS];
	logic [PW-1:0] prod_c [NS];
	logic [QW-1:0] root_c [NS];
	logic [NW-1:0] den_c  [NS];
	logic [NS-1:0] neg_c, kill_c;

	logic [RW-1:0] rem_s  [NS];
	logic [PW-1:0] prod_s [NS];
	logic [QW-1:0] root_s [NS];
	logic [NW-1:0] den_s  [NS];
	logic [NS-1:0] neg_s, kill_s;

	logic [QW:0]   r_inc;
	logic [OW-1:0] q_mag;
	logic [OW-1:0] q_s;
	logic          kill_s_out;

	genvar gk;
	generate
		for (gk = 0; gk < NS; gk++) begin : g_step
			localparam int J = NS - 1 - gk;
			logic [RW-1:0] trial;
			logic          fit;

			if (gk == 0) begin : g_first
				assign rem_c[gk]  = RW'(lane_in.num) << (2 * obfn_pkg::OUT_FRAC_BITS + 2);
				assign prod_c[gk] = '0;
				assign root_c[gk] = '0;
				assign den_c[gk]  = lane_in.den;
				assign neg_c[gk]  = lane_in.neg;
				assign kill_c[gk] = lane_in.kill;
			end else begin : g_next
				assign rem_c[gk]  = rem_s[gk-1];
				assign prod_c[gk] = prod_s[gk-1];
				assign root_c[gk] = root_s[gk-1];
				assign den_c[gk]  = den_s[gk-1];
				assign neg_c[gk]  = neg_s[gk-1];
				assign kill_c[gk] = kill_s[gk-1];
			end

			// (root + 2^J)^2 * den - root^2 * den
			assign trial = (RW'(prod_c[gk]) << (J + 1)) + (RW'(den_c[gk]) << (2 * J));
			assign fit   = trial <= rem_c[gk];

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gk]  <= fit ? (rem_c[gk] - trial) : rem_c[gk];
					prod_s[gk] <= fit ? (prod_c[gk] + (PW'(den_c[gk]) << J)) : prod_c[gk];
					root_s[gk] <= fit ? (root_c[gk] | (QW'(1) << J)) : root_c[gk];
					den_s[gk]  <= den_c[gk];
					neg_s[gk]  <= neg_c[gk];
					kill_s[gk] <= kill_c[gk];
				end
			end
		end
	endgenerate

	// root = floor(2t); round(t) = (root + 1) >> 1
	assign r_inc = {1'b0, root_s[NS-1]} + 1'b1;
	assign q_mag = r_inc[QW:1];

	always_ff @(posedge clk) begin
		if (en) begin
			q_s        <= kill_s[NS-1] ? '0 : (neg_s[NS-1] ? (~q_mag + 1'b1) : q_mag);
			kill_s_out <= kill_s[NS-1];
		end
	end

	assign q    = q_s;
	assign kill = kill_s_out;

endmodule

### rtl/core/orthonormal_basis_from_normal_unit.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_from_normal_unit
// Unit orthonormal basis (x, y, z axes) whose z axis follows the input vector.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one direction vector per item, m_* one basis per item.
//   s_tdata holds dir_x, dir_y, dir_z (signed Q16.16); m_tdata holds the nine
//   axis components (signed Q2.30, rounded to nearest, ties away from zero);
//   m_tuser is the degenerate flag, set with all-zero axes for a zero vector.
//   The pipeline has five front stages (magnitudes, products, lengths,
//   wide partial products, lane setup), 32 root-bit stages of the per-lane
//   square-root-of-quotient recurrence, and one rounding stage.
//   Throughput is one item per cycle while s_tready is high; every stage advances together.
//   A one-entry skid register behind the last stage catches an item the
//   receiver does not take; s_tready drops only while that register is full,
//   freezing the pipeline without losing or repeating an item.
//   Reset empties the pipeline and the skid register; m_tvalid is low after
//   reset and s_tready is high.
// ----------------------------------------------------------------------------
`include "orthonormal_basis_from_normal_unit_defines.svh"

module orthonormal_basis_from_normal_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [obfn_pkg::IN_TDATA_W-1:0]        s_tdata,  // dir_x, dir_y, dir_z
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z, zaxis_x, zaxis_y, zaxis_z
	output logic [obfn_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                   m_tuser   // degenerate
);

	localparam int IW = obfn_pkg::IN_WIDTH;
	localparam int OW = obfn_pkg::OUT_W;
	localparam int NL = obfn_pkg::NLANE;
	localparam int PS = obfn_pkg::PIPE_ST;

	logic                                  en;
	logic [PS-1:0]                         vld_q;
	logic                                  skid_full_q;
	logic [obfn_pkg::OUT_TDATA_W-1:0]      skid_data_q;
	logic                                  skid_deg_q;
	logic [obfn_pkg::OUT_TDATA_W-1:0]      pipe_data;
	obfn_pkg::lane_in_t [NL-1:0]           lanes;
	logic signed [OW-1:0]                  lane_q [NL];
	logic [NL-1:0]                         lane_kill;

	assign en       = ~skid_full_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PS-2:0], s_tvalid};
		end
	end

	obfn_front u_front (
		.clk   (clk),
		.en    (en),
		.dir_x (s_tdata[IW-1:0]),
		.dir_y (s_tdata[2*IW-1:IW]),
		.dir_z (s_tdata[3*IW-1:2*IW]),
		.lanes (lanes)
	);

	genvar gi;
	generate
		for (gi = 0; gi < NL; gi++) begin : g_lane
			obfn_lane u_lane (
				.clk     (clk),
				.en      (en),
				.lane_in (lanes[gi]),
				.q       (lane_q[gi]),
				.kill    (lane_kill[gi])
			);
			assign pipe_data[gi*OW +: OW] = lane_q[gi];
		end
		if (obfn_pkg::OUT_TDATA_W > NL * OW) begin : g_pad
			assign pipe_data[obfn_pkg::OUT_TDATA_W-1:NL*OW] = '0;
		end
	endgenerate

	// skid: last stage item not taken moves here while the pipeline steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (m_tready) begin
				skid_full_q <= 1'b0;
			end
		end else if (vld_q[PS-1] && !m_tready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_data_q <= pipe_data;
			skid_deg_q  <= lane_kill[0];
		end
	end

	assign m_tvalid = skid_full_q | vld_q[PS-1];
	assign m_tdata  = skid_full_q ? skid_data_q : pipe_data;
	assign m_tuser  = skid_full_q ? skid_deg_q : lane_kill[0];

	`OBFN_ASSERT_IMPLY(a_deg_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0, "degenerate item with nonzero axes")
	`OBFN_ASSERT_IMPLY(a_z_nonzero, clk, arst_n, m_tvalid && !m_tuser, (m_tdata[obfn_pkg::LANE_ZX*OW +: OW] != '0) || (m_tdata[obfn_pkg::LANE_ZY*OW +: OW] != '0) || (m_tdata[obfn_pkg::LANE_ZZ*OW +: OW] != '0), "unit z axis came out zero")
	`OBFN_ASSERT_NEVER(a_lane_sync, clk, arst_n, vld_q[PS-1] && (lane_kill != '0) && (lane_kill != '1), "lanes out of step on degenerate flag")

endmodule
